// ===== rtl/rtt_pkg.sv =====
package rtt_pkg;

  localparam int unsigned EntriesDef   = 16;
  localparam int unsigned RemW         = 23;
  localparam int unsigned RetryW       = 4;
  localparam int unsigned TimeoutW     = 8;
  localparam int unsigned IndexW       = 4;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 8;

  localparam logic [TimeoutW-1:0] InitTimeoutRst = 8'd20;
  localparam logic [RetryW-1:0]   MaxRetriesRst  = 4'd3;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_ARM     = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_CANCEL  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_DISARM     = 3'd1,
    ACT_RETX       = 3'd2,
    ACT_ABORT      = 3'd3,
    ACT_CANCEL_ERR = 3'd4
  } act_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INIT_TIMEOUT = 1'd0,
    CFG_MAX_RETRIES  = 1'd1
  } cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FINISH
  } st_e;

  typedef struct packed {
    req_e              req_type;
    logic [IndexW-1:0] entry_index;
    logic              send_buffer_empty;
  } req_t;

  typedef struct packed {
    logic [IndexW-1:0] result_index;
    act_e              action;
    logic [RetryW-1:0] retry_count;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [RemW-1:0]   remaining;
    logic [RetryW-1:0] retries;
  } entry_t;

endpackage

// ===== rtl/rtt_mem.sv =====
module rtt_mem #(
  parameter int unsigned Depth = rtt_pkg::EntriesDef,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  rtt_pkg::entry_t      wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output rtt_pkg::entry_t      rdata_o
);
  import rtt_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rtt_engine.sv =====
module rtt_engine #(
  parameter int unsigned Entries = rtt_pkg::EntriesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rtt_pkg::req_t                  in_data_i,
  input  logic [rtt_pkg::TimeoutW-1:0]   init_timeout_i,
  input  logic [rtt_pkg::RetryW-1:0]     max_retries_i,
  input  logic                           out_free_i,
  output logic                           emit_o,
  output rtt_pkg::res_t                  emit_res_o
);
  import rtt_pkg::*;

  localparam int unsigned AddrW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Entries - 1);

  st_e state_q, state_d;
  logic [AddrW-1:0] cur_q, cur_d;
  req_e req_q, req_d;
  logic [IndexW-1:0] idx_q, idx_d;
  logic buf_q, buf_d;
  logic pend_valid_q, pend_valid_d;
  res_t pend_q, pend_d;
  logic [Entries-1:0] armed_q, armed_d;

  logic mem_we, mem_re;
  logic [AddrW-1:0] mem_raddr;
  entry_t rd_entry;

  logic in_fire, in_range, armed_cur, scan_last, exec_stall;
  entry_t upd_entry;
  logic upd_armed, upd_write, upd_report;
  res_t upd_res;

  rtt_mem #(
    .Depth(Entries),
    .AddrW(AddrW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(cur_q),
    .wdata_i(upd_entry),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(rd_entry)
  );

  assign in_fire   = in_valid_i && in_ready_o;
  assign in_range  = 32'(in_data_i.entry_index) < 32'(Entries);
  assign armed_cur = armed_q[cur_q];
  assign scan_last = (cur_q == LastAddr);

  // Read-modify-write of the entry whose data sits in the read register.
  always_comb begin
    logic [RetryW-1:0] new_retries;
    new_retries = rd_entry.retries + RetryW'(1);
    upd_entry   = rd_entry;
    upd_armed   = armed_cur;
    upd_write   = 1'b0;
    upd_report  = 1'b0;
    upd_res     = '{result_index: IndexW'(cur_q), action: ACT_NONE,
                    retry_count: '0, last: 1'b1};
    unique case (req_q)
      REQ_TICK: begin
        if (armed_cur) begin
          upd_write = 1'b1;
          if (rd_entry.remaining > RemW'(1)) begin
            upd_entry.remaining = rd_entry.remaining - RemW'(1);
          end else begin
            upd_report   = 1'b1;
            upd_res.last = 1'b0;
            if (rd_entry.retries >= max_retries_i) begin
              upd_armed             = 1'b0;
              upd_entry.remaining   = '0;
              upd_res.action        = ACT_ABORT;
              upd_res.retry_count   = rd_entry.retries;
            end else begin
              upd_entry.retries   = new_retries;
              upd_entry.remaining = RemW'(init_timeout_i) << new_retries;
              upd_res.action      = ACT_RETX;
              upd_res.retry_count = new_retries;
            end
          end
        end
      end
      REQ_ARM: begin
        upd_write  = 1'b1;
        upd_armed  = 1'b1;
        upd_report = 1'b1;
        if (!armed_cur) begin
          upd_entry.retries = '0;
        end
        upd_entry.remaining = RemW'(init_timeout_i);
        upd_res.retry_count = upd_entry.retries;
      end
      REQ_RELEASE: begin
        upd_report = 1'b1;
        if (armed_cur) begin
          upd_res.retry_count = rd_entry.retries;
          if (buf_q) begin
            upd_armed      = 1'b0;
            upd_res.action = ACT_DISARM;
          end
        end
      end
      REQ_CANCEL: begin
        upd_report = 1'b1;
        if (armed_cur) begin
          upd_armed           = 1'b0;
          upd_res.action      = ACT_DISARM;
          upd_res.retry_count = rd_entry.retries;
        end else begin
          upd_res.action = ACT_CANCEL_ERR;
        end
      end
    endcase
  end

  // A tick only holds back when a second expiry must push the staged one out.
  assign exec_stall = (req_q == REQ_TICK) ? (upd_report && pend_valid_q && !out_free_i)
                                          : !out_free_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_data_i.req_type == REQ_TICK || in_range) ? ST_EXEC : ST_FINISH;
        end
      end
      ST_EXEC: begin
        if (!exec_stall) begin
          if (req_q != REQ_TICK) begin
            state_d = ST_IDLE;
          end else if (scan_last) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = cur_q;
    mem_we     = 1'b0;
    emit_o     = 1'b0;
    emit_res_o = upd_res;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        mem_re     = in_fire && (in_data_i.req_type == REQ_TICK || in_range);
        mem_raddr  = (in_data_i.req_type == REQ_TICK) ? '0 : AddrW'(in_data_i.entry_index);
      end
      ST_EXEC: begin
        if (!exec_stall) begin
          mem_we = upd_write;
          if (req_q == REQ_TICK) begin
            mem_re     = !scan_last;
            mem_raddr  = cur_q + AddrW'(1);
            emit_o     = upd_report && pend_valid_q;
            emit_res_o = pend_q;
          end else begin
            emit_o = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        emit_o = out_free_i;
        if (req_q != REQ_TICK) begin
          emit_res_o = '{result_index: idx_q, action: ACT_NONE, retry_count: '0, last: 1'b1};
        end else if (pend_valid_q) begin
          emit_res_o      = pend_q;
          emit_res_o.last = 1'b1;
        end else begin
          emit_res_o = '{result_index: '0, action: ACT_NONE, retry_count: '0, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cur_d        = cur_q;
    req_d        = req_q;
    idx_d        = idx_q;
    buf_d        = buf_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    armed_d      = armed_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          req_d = in_data_i.req_type;
          idx_d = in_data_i.entry_index;
          buf_d = in_data_i.send_buffer_empty;
          cur_d = mem_raddr;
        end
      end
      ST_EXEC: begin
        if (!exec_stall) begin
          armed_d[cur_q] = upd_armed;
          if (req_q == REQ_TICK) begin
            if (upd_report) begin
              pend_valid_d = 1'b1;
              pend_d       = upd_res;
            end
            if (!scan_last) begin
              cur_d = cur_q + AddrW'(1);
            end
          end
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          pend_valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cur_q        <= '0;
      req_q        <= REQ_TICK;
      pend_valid_q <= 1'b0;
      armed_q      <= '0;
    end else begin
      state_q      <= state_d;
      cur_q        <= cur_d;
      req_q        <= req_d;
      pend_valid_q <= pend_valid_d;
      armed_q      <= armed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    buf_q  <= buf_d;
    pend_q <= pend_d;
  end

  a_cur_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |-> 32'(cur_q) < 32'(Entries))
    else $error("entry pointer beyond the table");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && mem_re |-> mem_raddr != cur_q)
    else $error("read and write of the same entry in one cycle");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_valid_q)
    else $error("staged expiry left over after a tick");

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> out_free_i)
    else $error("result issued while the output register is full");

endmodule

// ===== rtl/retransmit_timer_table_top.sv =====
// Arm, release and cancel: the result is registered on leaving EXEC, or FINISH for an index beyond
//   the table, and the next request is taken back in IDLE; a stalled output delays both.
// Tick: one entry per cycle is read and, if armed, written back, unless an expiry finds one staged
//   and the output full; the last result is registered on leaving FINISH, then IDLE takes the next request.
// Reset clears the armed bits and loads the timeout and retry limit registers with 20 and 3;
// the timer memory itself is not cleared, as an entry's contents are only used after an arm wrote them.
module retransmit_timer_table_top #(
  parameter int unsigned Entries = rtt_pkg::EntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rtt_pkg::req_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rtt_pkg::res_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rtt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rtt_pkg::CfgDataW-1:0]  cfg_data_i
);
  import rtt_pkg::*;

  logic [TimeoutW-1:0] init_timeout_q;
  logic [RetryW-1:0]   max_retries_q;
  logic                out_valid_q;
  res_t                out_data_q;
  logic                out_free;
  logic                emit;
  res_t                emit_res;

  // Configuration writes are always taken and unchecked; the user must issue them only while the table is quiet.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_timeout_q <= InitTimeoutRst;
      max_retries_q  <= MaxRetriesRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_INIT_TIMEOUT: init_timeout_q <= cfg_data_i[TimeoutW-1:0];
        CFG_MAX_RETRIES:  max_retries_q  <= cfg_data_i[RetryW-1:0];
      endcase
    end
  end

  // The output register frees up in the same cycle its result is transferred,
  // so the engine can refill it without a bubble.
  assign out_free = !out_valid_q || out_ready_i;

  rtt_engine #(
    .Entries(Entries)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .init_timeout_i(init_timeout_q),
    .max_retries_i (max_retries_q),
    .out_free_i    (out_free),
    .emit_o        (emit),
    .emit_res_o    (emit_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= emit_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import rtt_pkg::*;

  localparam int unsigned Entries       = EntriesDef;
  // A tick walks the whole table, so let that much time pass before the block is taken as idle.
  localparam int unsigned SettleCycles  = Entries + 4;
  // Long receiver hold-off used to fill the block up and stall its input.
  localparam int unsigned LongHold      = 400;
  // Cycles without any transfer before the run is declared hung. The slowest legal stretch is
  // the long hold-off, or a long sender gap followed by a full table walk.
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned PrintLimit    = 40;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  req_t                in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  res_t                out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  retransmit_timer_table_top #(
    .Entries(Entries)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // The testbench's own copy of the timer table and its two registers.
  logic                timer_armed     [Entries];
  logic [RemW-1:0]     timer_remaining [Entries];
  logic [RetryW-1:0]   timer_retries   [Entries];
  logic [TimeoutW-1:0] initial_timeout;
  logic [RetryW-1:0]   retry_limit;

  // Timer events the block still owes, oldest first.
  res_t expected_events[$];

  int unsigned mismatch_count  = 0;
  int unsigned requests_sent   = 0;
  int unsigned ticks_sent      = 0;
  int unsigned events_checked  = 0;
  int unsigned expiries_seen   = 0;
  int unsigned register_writes = 0;
  int unsigned idle_cycles     = 0;

  // Bumped by a test each time the receiver is to take a LongHold hold-off.
  int unsigned hold_requests;
  // Random idling on or off, for the sender and the receiver separately.
  bit          sender_idles;
  bit          receiver_idles;

  always #5 clk_i = ~clk_i;

  // Mostly back to back, sometimes a short gap, now and then a long gap.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PrintLimit) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Works out the events that one accepted request causes and applies it to the local table.
  // A tick first decides which armed entries expire, so that the highest one can carry the
  // last flag, then walks the table in index order.
  task automatic advance_timer_table(input req_t req);
    res_t        ev;
    int          final_hit;
    logic [3:0]  idx;
    final_hit = -1;
    idx = req.entry_index;
    ev = '0;
    if (req.req_type == REQ_TICK) begin
      ticks_sent++;
      for (int i = 0; i < Entries; i++) begin
        if (timer_armed[i] && timer_remaining[i] <= 1) final_hit = i;
      end
      for (int i = 0; i < Entries; i++) begin
        if (timer_armed[i]) begin
          if (timer_remaining[i] > 1) begin
            timer_remaining[i] = timer_remaining[i] - 1'b1;
          end else begin
            timer_remaining[i] = '0;
            ev.result_index = IndexW'(i);
            ev.last = (i == final_hit);
            if (timer_retries[i] >= retry_limit) begin
              // Out of retries: the connection is aborted and the entry goes idle.
              timer_armed[i] = 1'b0;
              ev.action = ACT_ABORT;
            end else begin
              // Exponential backoff: the new timeout doubles with every retry.
              timer_retries[i] = timer_retries[i] + 1'b1;
              timer_remaining[i] = {{(RemW - TimeoutW){1'b0}}, initial_timeout}
                                   << timer_retries[i];
              ev.action = ACT_RETX;
            end
            ev.retry_count = timer_retries[i];
            expected_events.push_back(ev);
            expiries_seen++;
          end
        end
      end
      if (final_hit < 0) begin
        // Nothing expired: a single empty event for entry zero.
        ev = '0;
        ev.action = ACT_NONE;
        ev.last = 1'b1;
        expected_events.push_back(ev);
      end
    end else begin
      ev.result_index = idx;
      ev.last = 1'b1;
      ev.action = ACT_NONE;
      ev.retry_count = '0;
      case (req.req_type)
        REQ_ARM: begin
          // A fresh arm starts at retry zero; re-arming only reloads the timeout.
          if (!timer_armed[idx]) begin
            timer_armed[idx] = 1'b1;
            timer_retries[idx] = '0;
          end
          timer_remaining[idx] = {{(RemW - TimeoutW){1'b0}}, initial_timeout};
          ev.retry_count = timer_retries[idx];
        end
        REQ_RELEASE: begin
          if (timer_armed[idx]) begin
            ev.retry_count = timer_retries[idx];
            if (req.send_buffer_empty) begin
              timer_armed[idx] = 1'b0;
              ev.action = ACT_DISARM;
            end
          end
        end
        default: begin
          // Cancel of an idle entry is an error and reports retry count zero.
          if (timer_armed[idx]) begin
            timer_armed[idx] = 1'b0;
            ev.action = ACT_DISARM;
            ev.retry_count = timer_retries[idx];
          end else begin
            ev.action = ACT_CANCEL_ERR;
          end
        end
      endcase
      expected_events.push_back(ev);
    end
  endtask

  task automatic compare_event(input res_t got);
    res_t want;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("unexpected event idx=%0d action=%0d retries=%0d last=%0d",
                                got.result_index, got.action, got.retry_count, got.last));
    end else begin
      want = expected_events.pop_front();
      events_checked++;
      if (got.result_index !== want.result_index)
        report_mismatch($sformatf("result_index %0d, expected %0d",
                                  got.result_index, want.result_index));
      if (got.action !== want.action)
        report_mismatch($sformatf("entry %0d action %0d, expected %0d",
                                  want.result_index, got.action, want.action));
      if (got.retry_count !== want.retry_count)
        report_mismatch($sformatf("entry %0d retry_count %0d, expected %0d",
                                  want.result_index, got.retry_count, want.retry_count));
      if (got.last !== want.last)
        report_mismatch($sformatf("entry %0d last %0d, expected %0d",
                                  want.result_index, got.last, want.last));
    end
  endtask

  // All transfers are observed at the rising edge, before the block's own registers move.
  // While reset is held the local table and registers return to their reset values.
  // Requests are predicted in the order they are accepted, events are checked in the order
  // they leave, and the watchdog counts edges with no transfer on any channel.
  always @(posedge clk_i) begin
    logic moved;
    moved = 1'b0;
    if (!rst_ni) begin
      initial_timeout = InitTimeoutRst;
      retry_limit = MaxRetriesRst;
      for (int i = 0; i < Entries; i++) begin
        timer_armed[i] = 1'b0;
        timer_remaining[i] = '0;
        timer_retries[i] = '0;
      end
      idle_cycles = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        register_writes++;
        case (cfg_e'(cfg_index_i))
          CFG_INIT_TIMEOUT: initial_timeout = cfg_data_i[TimeoutW-1:0];
          default:          retry_limit = cfg_data_i[RetryW-1:0];
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        requests_sent++;
        advance_timer_table(in_data_i);
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        compare_event(out_data_o);
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("[%0t] Timeout: no transfer for %0d cycles, %0d events outstanding.",
                 $time, idle_cycles, expected_events.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Receiver: ready changes only at the falling edge. A new hold-off request wins over
  // everything else; otherwise ready stays high, or idles at random when that is switched on.
  initial begin : receiver
    int unsigned pause;
    int unsigned holds_taken;
    holds_taken = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (holds_taken != hold_requests) begin
        holds_taken = hold_requests;
        out_ready_i = 1'b0;
        repeat (LongHold) @(negedge clk_i);
        out_ready_i = 1'b1;
      end else if (!receiver_idles) begin
        out_ready_i = 1'b1;
      end else begin
        pause = pick_gap();
        if (pause == 0) begin
          out_ready_i = 1'b1;
        end else begin
          out_ready_i = 1'b0;
          repeat (pause) @(negedge clk_i);
          out_ready_i = 1'b1;
        end
      end
    end
  end

  // Offers one request after an optional gap and returns at the edge where it is taken.
  // Valid is left high on return; the next call, a register write or a drain wait changes it
  // at the very next falling edge, so the block never sees the same request twice.
  task automatic send_request(input req_e kind, input logic [IndexW-1:0] idx,
                              input logic buf_empty, input int unsigned gap);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i.req_type = kind;
    in_data_i.entry_index = idx;
    in_data_i.send_buffer_empty = buf_empty;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_random_request();
    int unsigned roll;
    req_e        kind;
    roll = $urandom_range(0, 99);
    if (roll < 40)      kind = REQ_TICK;
    else if (roll < 70) kind = REQ_ARM;
    else if (roll < 85) kind = REQ_RELEASE;
    else                kind = REQ_CANCEL;
    // The index and buffer bits ride along on ticks too; the block must ignore them there.
    send_request(kind, IndexW'($urandom_range(0, Entries - 1)), 1'($urandom_range(0, 1)),
                 sender_idles ? pick_gap() : 0);
  endtask

  // Stops offering and waits until every predicted event has been checked, then gives the
  // block time to finish a table walk before anything else happens.
  task automatic wait_until_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_events.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Only called while the block is idle.
  task automatic write_register(input cfg_e idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_timers(input logic [TimeoutW-1:0] timeout, input logic [RetryW-1:0] limit);
    write_register(CFG_INIT_TIMEOUT, timeout);
    write_register(CFG_MAX_RETRIES, {{(CfgDataW - RetryW){1'b0}}, limit});
  endtask

  // Release and cancel of idle entries, and a tick on an empty table, under reset values.
  task automatic test_idle_entries();
    send_request(REQ_RELEASE, 4'd0, 1'b0, 0);
    send_request(REQ_RELEASE, 4'd15, 1'b1, 0);
    send_request(REQ_CANCEL, 4'd0, 1'b0, 0);
    send_request(REQ_CANCEL, 4'd15, 1'b1, 0);
    send_request(REQ_TICK, 4'd15, 1'b1, 0);
    wait_until_drained();
  endtask

  // Arm, re-arm, release with and without data in flight, cancel of armed and idle entries.
  task automatic test_arm_release_cancel();
    send_request(REQ_ARM, 4'd0, 1'b0, 0);
    send_request(REQ_ARM, 4'd15, 1'b1, 0);
    send_request(REQ_ARM, 4'd0, 1'b1, 0);
    send_request(REQ_RELEASE, 4'd0, 1'b0, 0);
    send_request(REQ_RELEASE, 4'd0, 1'b1, 0);
    send_request(REQ_CANCEL, 4'd15, 1'b0, 0);
    send_request(REQ_CANCEL, 4'd15, 1'b0, 0);
    wait_until_drained();
  endtask

  // Zero timeout with no retries aborts on the first tick. Then two entries walk through
  // backoff together until they abort in the same tick, and finally the largest settings.
  task automatic test_backoff_and_abort();
    set_timers(8'd0, 4'd0);
    send_request(REQ_ARM, 4'd3, 1'b0, 0);
    send_request(REQ_TICK, 4'd0, 1'b0, 0);
    wait_until_drained();
    set_timers(8'd1, 4'd2);
    send_request(REQ_ARM, 4'd5, 1'b0, 0);
    send_request(REQ_ARM, 4'd9, 1'b0, 0);
    repeat (7) send_request(REQ_TICK, 4'd0, 1'b0, 0);
    wait_until_drained();
    set_timers(8'd255, 4'd15);
    send_request(REQ_ARM, 4'd7, 1'b0, 0);
    send_request(REQ_TICK, 4'd0, 1'b0, 0);
    send_request(REQ_CANCEL, 4'd7, 1'b0, 0);
    wait_until_drained();
  endtask

  // Every entry expires on the same tick while the receiver holds off for a long stretch, so
  // the block has to stall its input while the sender keeps offering ticks back to back.
  task automatic test_full_table_backpressure();
    set_timers(8'd1, 4'd1);
    for (int i = 0; i < Entries; i++) send_request(REQ_ARM, IndexW'(i), 1'b0, 0);
    hold_requests++;
    repeat (5) send_request(REQ_TICK, 4'd0, 1'b0, 0);
    wait_until_drained();
  endtask

  // Random traffic over several register settings, extremes included, with idling switched
  // on and off between phases and the odd full drain in the middle.
  task automatic test_random_traffic();
    logic [TimeoutW-1:0] timeouts [5];
    logic [RetryW-1:0]   limits   [5];
    timeouts = '{8'd1, 8'd2, 8'd255, 8'd3, 8'd1};
    limits   = '{4'd0, 4'd3, 4'd15, 4'd15, 4'd1};
    timeouts[4] = TimeoutW'($urandom_range(1, 6));
    limits[4] = RetryW'($urandom_range(0, 4));
    for (int phase = 0; phase < 5; phase++) begin
      set_timers(timeouts[phase], limits[phase]);
      sender_idles = (phase != 1);
      receiver_idles = (phase != 1);
      for (int n = 0; n < 15; n++) begin
        send_random_request();
        if ($urandom_range(0, 19) == 0) wait_until_drained();
      end
      wait_until_drained();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    hold_requests = 0;
    sender_idles = 1'b0;
    receiver_idles = 1'b0;

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_entries();
    test_arm_release_cancel();
    test_backoff_and_abort();
    test_full_table_backpressure();
    test_random_traffic();

    wait_until_drained();
    $display("Sent %0d requests (%0d ticks) over %0d register writes.",
             requests_sent, ticks_sent, register_writes);
    $display("Checked %0d timer events, %0d of them expiries; %0d mismatches.",
             events_checked, expiries_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
